[rtl/wsp_pkg.sv]
package wsp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ACC_W = 50;
    localparam int NUM_W = ACC_W + FRAC_BITS;
    localparam int Q_W = NUM_W;

    localparam logic [0:0] OP_LOAD = 1'b0;
    localparam logic [0:0] OP_PROJECT = 1'b1;

    localparam logic [0:0] REG_WIDTH = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [0:0] opcode;
        logic [3:0] entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } wsp_in_t;

    typedef struct packed {
        logic [0:0] visible;
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
    } wsp_out_t;

    // controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       write_entry;
        logic       clear_acc;
        logic       mac;
        logic [1:0] row;
        logic [1:0] col;
        logic       store_row;
        logic       div_start;
        logic       div_sel;
        logic       div_step;
        logic       store_q;
        logic       scale;
        logic       set_invis;
    } wsp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_load;
        logic visible;
        logic div_done;
    } wsp_stat_t;

endpackage

[rtl/wsp_datapath.sv]
module wsp_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  wsp_pkg::wsp_in_t   in_item,
    input  wsp_pkg::wsp_cmd_t  cmd,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_idx,
    input  logic [13:0]        cfg_data,
    output wsp_pkg::wsp_stat_t stat,
    output wsp_pkg::wsp_out_t  result
);
    import wsp_pkg::*;

    logic signed [31:0] mat_reg [16];
    logic [13:0] ww_reg, wh_reg;
    wsp_in_t item_reg;
    logic signed [ACC_W-1:0] acc_reg, cx_reg, cy_reg, cw_reg;
    logic signed [ACC_W-1:0] nx_reg, ny_reg;
    logic [ACC_W-1:0] rem_reg;
    logic [Q_W-1:0] q_reg;
    logic [6:0] cnt_reg;
    logic div_neg_reg, div_busy_reg;
    logic vis_reg;
    wsp_out_t res_reg;

    // shared multiplier operands
    logic [3:0] midx;
    logic signed [31:0] mop;
    logic signed [31:0] pop;
    logic signed [63:0] prod;
    logic signed [ACC_W-1:0] addend;

    assign midx = {cmd.col, cmd.row};
    assign mop = mat_reg[midx];
    always_comb begin
        unique case (cmd.col)
            2'd0: pop = item_reg.point_x;
            2'd1: pop = item_reg.point_y;
            2'd2: pop = item_reg.point_z;
            default: pop = 32'sd0;
        endcase
    end
    assign prod = pop * mop;
    // arithmetic shift floors toward minus infinity
    always_comb begin
        if (cmd.col == 2'd3) addend = ACC_W'(mop);
        else addend = ACC_W'(prod >>> FRAC_BITS);
    end

    // divider operands
    logic signed [ACC_W-1:0] dnum;
    logic [ACC_W-1:0] dabs;
    logic [ACC_W-1:0] rem_sh;
    logic [ACC_W:0] trial;
    logic [Q_W-1:0] qn;
    assign dnum = cmd.div_sel ? cy_reg : cx_reg;
    assign dabs = dnum[ACC_W-1] ? ACC_W'(-dnum) : dnum;
    // next dividend bit shifts into the partial remainder
    assign rem_sh = {rem_reg[ACC_W-2:0], q_reg[Q_W-1]};
    assign trial = {1'b0, rem_sh} - {1'b0, cw_reg};
    assign qn = {q_reg[Q_W-2:0], !trial[ACC_W]};
    localparam logic [Q_W-1:0] CLAMP = Q_W'(64'd1 << 40);

    function automatic logic [Q_W-1:0] qc();
        return (q_reg >= CLAMP) ? CLAMP : q_reg;
    endfunction

    // visibility and scaling
    logic signed [14:0] hw, hh;
    logic signed [ACC_W+16:0] sx, sy;
    logic signed [31:0] sxs, sys;
    assign hw = 15'(ww_reg >> 1);
    assign hh = 15'(wh_reg >> 1);
    assign sx = (ACC_W+17)'(hw + 15'sd1) * (ACC_W+17)'(nx_reg)
              + ((ACC_W+17)'(hw) <<< FRAC_BITS);
    assign sy = (ACC_W+17)'(15'sd1 - hh) * (ACC_W+17)'(ny_reg)
              + ((ACC_W+17)'(hh) <<< FRAC_BITS);

    function automatic logic signed [31:0] sat(input logic signed [ACC_W+16:0] v);
        if (v > (ACC_W+17)'(32'sh7fffffff)) return 32'sh7fffffff;
        else if (v < -(ACC_W+17)'(64'sh80000000)) return 32'sh80000000;
        else return v[31:0];
    endfunction
    assign sxs = sat(sx);
    assign sys = sat(sy);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ww_reg <= 14'd1920;
            wh_reg <= 14'd1080;
        end else if (cfg_we) begin
            if (cfg_idx == REG_WIDTH) ww_reg <= cfg_data;
            else wh_reg <= cfg_data;
        end
    end

    // matrix
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) mat_reg[i] <= '0;
        end else if (cmd.write_entry) begin
            mat_reg[item_reg.entry_index] <= item_reg.entry_value;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) item_reg <= in_item;
        if (cmd.clear_acc) acc_reg <= '0;
        else if (cmd.mac) acc_reg <= acc_reg + addend;
        if (cmd.store_row) begin
            unique case (cmd.row)
                2'd0: cx_reg <= acc_reg;
                2'd1: cy_reg <= acc_reg;
                default: cw_reg <= acc_reg;
            endcase
        end
        if (cmd.store_row && cmd.row == 2'd3)
            vis_reg <= !(((ACC_W+5)'(acc_reg) * (ACC_W+5)'(10))
                         < (ACC_W+5)'(64'sd1 <<< FRAC_BITS));
        if (cmd.div_start) begin
            rem_reg <= '0;
            q_reg <= {dabs, {FRAC_BITS{1'b0}}};
            div_neg_reg <= dnum[ACC_W-1];
        end else if (cmd.div_step && div_busy_reg) begin
            // restoring division, one quotient bit a cycle
            rem_reg <= trial[ACC_W] ? rem_sh : trial[ACC_W-1:0];
            q_reg <= qn;
        end
        if (cmd.store_q) begin
            if (cmd.div_sel) ny_reg <= div_neg_reg ? -ACC_W'(qc()) : ACC_W'(qc());
            else nx_reg <= div_neg_reg ? -ACC_W'(qc()) : ACC_W'(qc());
        end
        if (cmd.set_invis) res_reg <= '0;
        else if (cmd.scale) res_reg <= {1'b1, sxs, sys};
    end

    // divider step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            div_busy_reg <= 1'b0;
        end else if (cmd.div_start) begin
            cnt_reg <= 7'(NUM_W - 1);
            div_busy_reg <= 1'b1;
        end else if (cmd.div_step && div_busy_reg) begin
            if (cnt_reg == '0) div_busy_reg <= 1'b0;
            else cnt_reg <= cnt_reg - 7'd1;
        end
    end

    assign stat.is_load = (item_reg.opcode == OP_LOAD);
    assign stat.visible = vis_reg;
    assign stat.div_done = !div_busy_reg;
    assign result = res_reg;
endmodule

[rtl/wsp_ctrl.sv]
module wsp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  wsp_pkg::wsp_stat_t stat,
    output wsp_pkg::wsp_cmd_t  cmd
);
    import wsp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_MAC  = 3'd2;
    localparam logic [2:0] S_DIVS = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_SCL  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] row_reg, row_next, col_reg, col_next;
    logic sel_reg, sel_next;
    logic mv_reg, mv_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        row_next = row_reg;
        col_next = col_reg;
        sel_next = sel_reg;
        mv_next = mv_reg;
        cmd = '0;
        cmd.row = row_reg;
        cmd.col = col_reg;
        cmd.div_sel = sel_reg;
        if (mv_reg && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (stat.is_load) begin
                    cmd.write_entry = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    cmd.clear_acc = 1'b1;
                    row_next = 2'd0;
                    col_next = 2'd0;
                    state_next = S_MAC;
                end
            end
            S_MAC: begin
                cmd.mac = 1'b1;
                col_next = col_reg + 2'd1;
                // the translation column ends the row
                if (col_reg == 2'd3) state_next = S_SCL;
            end
            S_SCL: begin
                // store row, advance
                cmd.store_row = 1'b1;
                cmd.clear_acc = 1'b1;
                if (row_reg == 2'd3) begin
                    sel_next = 1'b0;
                    state_next = S_DIVS;
                end else begin
                    row_next = (row_reg == 2'd1) ? 2'd3 : row_reg + 2'd1;
                    state_next = S_MAC;
                end
            end
            S_DIVS: begin
                if (!stat.visible) begin
                    if (!mv_reg) begin
                        cmd.set_invis = 1'b1;
                        mv_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    cmd.div_step = 1'b0;
                    cmd.store_q = 1'b1;
                    if (sel_reg) begin
                        state_next = S_OUT;
                    end else begin
                        sel_next = 1'b1;
                        state_next = S_DIVS;
                    end
                end
            end
            S_OUT: begin
                if (!mv_reg) begin
                    cmd.scale = 1'b1;
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            row_reg <= '0;
            col_reg <= '0;
            sel_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg <= row_next;
            col_reg <= col_next;
            sel_reg <= sel_next;
            mv_reg <= mv_next;
        end
    end
endmodule

[rtl/world_to_screen_projection_core.sv]
// after accept: a matrix load writes its entry and returns to idle; a point
// multiply-accumulates the x, y and w rows with a row store after each; an invisible
// point then gives its result, a visible one runs two serial divides and scaling;
// one shared 32x32 multiplier; flow: one item at a time, a new item only once the last
// is through, and a waiting result holds back the next one
// reset: synchronous active-low aresetn clears the matrix, window 1920x1080
module world_to_screen_projection_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wsp_pkg::wsp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output wsp_pkg::wsp_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [13:0]       cfg_data
);
    import wsp_pkg::*;

    wsp_cmd_t cmd;
    wsp_stat_t stat;

    assign cfg_ready = 1'b1;

    wsp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .stat(stat), .cmd(cmd)
    );

    wsp_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_item(s_data), .cmd(cmd),
        .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .stat(stat), .result(m_data)
    );
endmodule
